FILE: design/tzcpt_pkg.sv
// ----------------------------------------------------------------------------
// tzcpt_pkg
// Shared types and constants for the triac zero-cross phase timer.
// ----------------------------------------------------------------------------
package tzcpt_pkg;

  localparam int TIMER_BITS        = 16;
  localparam int FEED_FRAME_CYCLES = 1000;
  localparam int FEED_STEP_CYCLES  = 100;

  localparam int FEED_CNT_W        = 10;
  localparam int FEED_DUTY_DEFAULT = 250;
  localparam int FEED_DUTY_W       = 4;

  localparam int PHASE_W           = 8;
  localparam int PHASE_PROD_W      = 15;
  localparam int PHASE_UNIT        = 100;
  localparam int PHASE_ZERO_SUBST  = 60;
  localparam int SMOKE_PHASE_RESET = 90;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOKE_ENABLE    = 3'd0,
    CFG_SMOKE_PHASE     = 3'd1,
    CFG_EXCHANGE_ENABLE = 3'd2,
    CFG_FEED_ENABLE     = 3'd3,
    CFG_FEED_DUTY       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        edge_rising;
    logic [15:0] edge_time;
  } edge_item_t;

  typedef struct packed {
    logic        smoke_fire;
    logic [15:0] smoke_delay;
    logic        exchange_fire;
    logic        feed_fire;
    logic [15:0] zero_delay;
    logic [14:0] half_period;
  } result_t;

  typedef struct packed {
    logic                   enable;
    logic [FEED_DUTY_W-1:0] duty;
  } feed_cfg_t;

endpackage

FILE: design/tzcpt_edge_track.sv
// ----------------------------------------------------------------------------
// tzcpt_edge_track
// Edge time history, mains period and next zero-crossing delay.
// ----------------------------------------------------------------------------
module tzcpt_edge_track import tzcpt_pkg::*; #(
  parameter int TimerBits = TIMER_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  edge_item_t           item_i,
  output logic                 emit_o,
  output logic [TimerBits-1:0] zero_delay_o,
  output logic [TimerBits-1:0] period_o
);

  logic [TimerBits-1:0] older_fall_q, older_rise_q, last_fall_q;
  logic [TimerBits-1:0] period_q, zero_delay_q;
  logic [TimerBits-1:0] now;
  logic [TimerBits:0]   sum_a, sum_b;
  logic [TimerBits-1:0] mid_a, mid_b, period_new, delay_new;
  logic                 in_order;

  assign now      = TimerBits'(item_i.edge_time);
  assign in_order = (older_fall_q < older_rise_q) && (older_rise_q < last_fall_q) &&
                    (last_fall_q < now);

  // midpoints keep the carry before halving
  assign sum_a      = {1'b0, older_fall_q} + {1'b0, older_rise_q};
  assign sum_b      = {1'b0, last_fall_q} + {1'b0, now};
  assign mid_a      = sum_a[TimerBits:1];
  assign mid_b      = sum_b[TimerBits:1];
  assign period_new = mid_b - mid_a;
  assign delay_new  = mid_b + (period_new >> 2) - now;

  assign period_o     = in_order ? period_new : period_q;
  assign zero_delay_o = in_order ? delay_new  : zero_delay_q;
  assign emit_o       = item_i.edge_rising && (zero_delay_o != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_fall_q <= '0;
      older_rise_q <= '0;
      last_fall_q  <= '0;
      period_q     <= '0;
      zero_delay_q <= '0;
    end else if (step_i) begin
      if (item_i.edge_rising) begin
        period_q     <= period_o;
        zero_delay_q <= zero_delay_o;
        older_fall_q <= last_fall_q;
        older_rise_q <= now;
      end else begin
        last_fall_q <= now;
      end
    end
  end

endmodule

FILE: design/tzcpt_feed_duty.sv
// ----------------------------------------------------------------------------
// tzcpt_feed_timer
// On/off duty counter for the feed motor channel, counted in mains cycles.
// ----------------------------------------------------------------------------
module tzcpt_feed_timer import tzcpt_pkg::*; #(
  parameter int FeedFrameCycles = FEED_FRAME_CYCLES,
  parameter int FeedStepCycles  = FEED_STEP_CYCLES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  feed_cfg_t cfg_i,
  output logic      fire_o
);

  localparam int ProdW = $clog2(((1 << FEED_DUTY_W) - 1) * FeedStepCycles + 1);

  logic [FEED_CNT_W-1:0] count_q, count_d, count_inc;
  logic                  running_q, running_d;
  logic [ProdW-1:0]      prod;
  logic [FEED_CNT_W-1:0] on_cycles, off_cycles;

  always_comb begin
    prod = ProdW'(cfg_i.duty) * ProdW'(FeedStepCycles);
    if (cfg_i.duty == '0) begin
      on_cycles  = FEED_CNT_W'(FEED_DUTY_DEFAULT);
      off_cycles = FEED_CNT_W'(FEED_DUTY_DEFAULT);
    end else begin
      // on time saturates at the full frame
      on_cycles  = (int'(prod) > FeedFrameCycles) ? FEED_CNT_W'(FeedFrameCycles)
                                                  : FEED_CNT_W'(prod);
      off_cycles = FEED_CNT_W'(FeedFrameCycles) - on_cycles;
    end
  end

  assign count_inc = count_q + FEED_CNT_W'(1);
  assign fire_o    = cfg_i.enable && running_q;

  always_comb begin
    count_d   = count_q;
    running_d = running_q;
    if (step_i && cfg_i.enable) begin
      count_d = count_inc;
      if (running_q) begin
        if (count_inc >= on_cycles) begin
          count_d   = '0;
          running_d = 1'b0;
        end
      end else if (count_inc >= off_cycles) begin
        count_d   = '0;
        running_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      running_q <= 1'b1;
    end else begin
      count_q   <= count_d;
      running_q <= running_d;
    end
  end

endmodule

FILE: design/triac_zero_cross_phase_timer.sv
// ----------------------------------------------------------------------------
// triac_zero_cross_phase_timer
// Zero-cross edge timing to triac firing delays for smoke, exchange and feed.
// ----------------------------------------------------------------------------
// Takes one detector edge item per clock cycle with no gaps while the output
// register is not held. An accepted item sits in the input register while the
// edge tracker (and, for a result, the feed counter) updates, and its result
// (if any) is loaded into the output register as the item leaves the input
// register; a result held by the receiver keeps the input register, and with
// it the input, stalled until it is taken. Throughput is one item per cycle
// while results are taken, as the edge tracker updates its state as each item
// steps; only rising edges with a nonzero zero-crossing delay produce a result.
// Configuration writes take effect at once and should be made while no item is in flight.
module triac_zero_cross_phase_timer import tzcpt_pkg::*; #(
  parameter int TimerBits       = TIMER_BITS,
  parameter int FeedFrameCycles = FEED_FRAME_CYCLES,
  parameter int FeedStepCycles  = FEED_STEP_CYCLES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  edge_item_t            in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_t               out_data_o
);

  localparam int ExtW = (TimerBits > 16) ? TimerBits : 16;

  // configuration
  logic               smoke_en_q, exchange_en_q;
  logic [PHASE_W-1:0] smoke_phase_q;
  feed_cfg_t          feed_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoke_en_q    <= 1'b0;
      smoke_phase_q <= PHASE_W'(SMOKE_PHASE_RESET);
      exchange_en_q <= 1'b0;
      feed_cfg_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SMOKE_ENABLE:    smoke_en_q      <= cfg_wdata_i[0];
        CFG_SMOKE_PHASE:     smoke_phase_q   <= cfg_wdata_i[PHASE_W-1:0];
        CFG_EXCHANGE_ENABLE: exchange_en_q   <= cfg_wdata_i[0];
        CFG_FEED_ENABLE:     feed_cfg_q.enable <= cfg_wdata_i[0];
        CFG_FEED_DUTY:       feed_cfg_q.duty <= cfg_wdata_i[FEED_DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  edge_item_t in_item_q;
  logic       advance, step;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign step       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
  end

  // processing
  logic                 emit, feed_fire;
  logic [TimerBits-1:0] zero_delay, period, half_period, smoke_delay;
  logic [PHASE_W-1:0]   phase;
  logic [PHASE_PROD_W-1:0] phase_ticks;

  tzcpt_edge_track #(
    .TimerBits(TimerBits)
  ) u_edge_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .emit_o      (emit),
    .zero_delay_o(zero_delay),
    .period_o    (period)
  );

  tzcpt_feed_timer #(
    .FeedFrameCycles(FeedFrameCycles),
    .FeedStepCycles (FeedStepCycles)
  ) u_feed_timer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step && emit),
    .cfg_i (feed_cfg_q),
    .fire_o(feed_fire)
  );

  assign phase       = (smoke_phase_q == '0) ? PHASE_W'(PHASE_ZERO_SUBST) : smoke_phase_q;
  assign phase_ticks = PHASE_PROD_W'(phase) * PHASE_PROD_W'(PHASE_UNIT);
  assign half_period = period >> 1;
  assign smoke_delay = zero_delay + half_period - TimerBits'(phase_ticks);

  // output register
  logic    out_valid_q;
  result_t out_q;
  logic [ExtW-1:0] smoke_delay_ext, zero_delay_ext, half_period_ext;

  assign smoke_delay_ext = ExtW'(smoke_delay);
  assign zero_delay_ext  = ExtW'(zero_delay);
  assign half_period_ext = ExtW'(half_period);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q.smoke_fire    <= smoke_en_q;
      out_q.smoke_delay   <= smoke_delay_ext[15:0];
      out_q.exchange_fire <= exchange_en_q;
      out_q.feed_fire     <= feed_fire;
      out_q.zero_delay    <= zero_delay_ext[15:0];
      out_q.half_period   <= half_period_ext[14:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
